/* design/tohp_pkg.sv */
`default_nettype none
package tohp_pkg;

    localparam int unsigned MAX_VLAN_TAGS_DEF   = 2;
    localparam int unsigned MAX_EXT_HEADERS_DEF = 4;
    localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

    localparam logic [7:0] IPV4_CODE_RST = 8'h88;
    localparam logic [7:0] IPV6_CODE_RST = 8'h1e;
    localparam logic [5:0] MAX_OPT_RST   = 6'd10;

    localparam logic [1:0] REG_IPV4_CODE = 2'd0;
    localparam logic [1:0] REG_IPV6_CODE = 2'd1;
    localparam logic [1:0] REG_MAX_OPT   = 2'd2;

    typedef enum logic [3:0] {
        PH_ETH  = 4'd0,
        PH_VLAN = 4'd1,
        PH_IP4  = 4'd2,
        PH_IP6  = 4'd3,
        PH_EXT  = 4'd4,
        PH_TCP  = 4'd5,
        PH_DONE = 4'd6,
        PH_FAIL = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        SC_DONE = 2'd0,
        SC_TYPE = 2'd1,
        SC_LEN  = 2'd2,
        SC_OPT  = 2'd3
    } t_scan;

    typedef struct packed {
        logic [7:0] ipv4_code;
        logic [7:0] ipv6_code;
        logic [5:0] max_opt;
    } t_cfg;

    typedef struct packed {
        logic        conn_valid;
        logic        is_ipv6;
        logic        trace_found;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [63:0] trace_id_hi;
        logic [63:0] trace_id_lo;
        logic [63:0] span_id;
    } t_result;

endpackage
`default_nettype wire

/* design/tohp_cfg_regs.sv */
`default_nettype none
module tohp_cfg_regs
    import tohp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output t_cfg            o_cfg
);
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ipv4_code <= IPV4_CODE_RST;
            r_cfg.ipv6_code <= IPV6_CODE_RST;
            r_cfg.max_opt   <= MAX_OPT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IPV4_CODE: r_cfg.ipv4_code <= i_cfg_data;
                REG_IPV6_CODE: r_cfg.ipv6_code <= i_cfg_data;
                REG_MAX_OPT:   r_cfg.max_opt   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* design/tohp_parser.sv */
`default_nettype none
module tohp_parser
    import tohp_pkg::*;
#(
    parameter int unsigned MAX_VLAN_TAGS   = MAX_VLAN_TAGS_DEF,
    parameter int unsigned MAX_EXT_HEADERS = MAX_EXT_HEADERS_DEF,
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  t_cfg            i_cfg,
    output logic            o_res_valid,
    output t_result         o_res
);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int HW = $clog2(MAX_VLAN_TAGS + MAX_EXT_HEADERS + 1);

    logic [PW-1:0] r_pos, n_pos, r_nho, n_nho;
    t_phase        r_ph, n_ph;
    logic [15:0]   r_proto, n_proto;
    logic [HW-1:0] r_hc, n_hc;
    logic [5:0]    r_oc, n_oc;
    logic [63:0]   r_addr [4];
    logic [63:0]   n_addr [4];
    logic [15:0]   r_port [2];
    logic [15:0]   n_port [2];
    logic [63:0]   r_tr [2];
    logic [63:0]   n_tr [2];
    logic [63:0]   r_span, n_span;
    logic          r_fv6, n_fv6, r_fconn, n_fconn, r_ftr, n_ftr, r_fcand, n_fcand;
    logic [6:0]    r_ip4len, n_ip4len;
    t_scan         r_sm, n_sm;
    logic [6:0]    r_sp, n_sp;
    logic [11:0]   r_elen, n_elen;
    logic [7:0]    r_enext, n_enext;

    logic [PW-1:0] rr;
    logic [11:0]   r;
    logic [7:0]    b;
    logic [15:0]   t;
    logic [11:0]   sp;
    logic [11:0]   advlen;
    logic          act;
    logic          walk;
    logic [7:0]    wproto;

    assign b  = i_byte;
    assign rr = r_pos - r_nho;
    assign r  = 12'(rr);
    assign sp = {5'd0, r_sp};

    // per-byte parse step
    always_comb begin
        n_pos = r_pos; n_nho = r_nho; n_ph = r_ph; n_proto = r_proto;
        n_hc = r_hc; n_oc = r_oc; n_addr = r_addr; n_port = r_port;
        n_tr = r_tr; n_span = r_span; n_fv6 = r_fv6; n_fconn = r_fconn;
        n_ftr = r_ftr; n_fcand = r_fcand; n_ip4len = r_ip4len; n_sm = r_sm;
        n_sp = r_sp; n_elen = r_elen; n_enext = r_enext;
        t = 16'd0; walk = 1'b0; wproto = 8'd0; advlen = 12'd0;
        act = (32'(r_pos) < MAX_FRAME_BYTES);
        if (act) begin
            n_pos = r_pos + 1'b1;
            case (r_ph)
                PH_ETH, PH_VLAN: begin
                    if (r == ((r_ph == PH_ETH) ? 12'd12 : 12'd2)) begin
                        n_proto = {b, 8'd0};
                    end else if (r == ((r_ph == PH_ETH) ? 12'd13 : 12'd3)) begin
                        t = {r_proto[15:8], b};
                        n_proto = t;
                        n_nho = r_pos + 1'b1;
                        if ((t == 16'h8100 || t == 16'h88a8)
                            && 32'(r_hc) < MAX_VLAN_TAGS) begin
                            n_hc = r_hc + 1'b1; n_ph = PH_VLAN;
                        end else if (t == 16'h0800) begin
                            n_hc = '0; n_ph = PH_IP4;
                        end else if (t == 16'h86dd) begin
                            n_hc = '0; n_ph = PH_IP6; n_fv6 = 1'b1;
                        end else begin
                            n_ph = PH_FAIL;
                        end
                    end
                end
                PH_IP4: begin
                    if (r == 12'd0) begin
                        if (b[7:4] != 4'd4 || b[3:0] < 4'd5) begin
                            n_ph = PH_FAIL;
                        end else begin
                            n_ip4len = {1'b0, b[3:0], 2'b00};
                            n_sp = 7'd20;
                            n_sm = (b[3:0] > 4'd5) ? SC_TYPE : SC_DONE;
                        end
                    end else if (r == 12'd9 && b != 8'd6) begin
                        n_ph = PH_FAIL;
                    end else begin
                        if (r >= 12'd12 && r < 12'd16)
                            n_addr[1] = {r_addr[1][55:0], b};
                        else if (r >= 12'd16 && r < 12'd20)
                            n_addr[3] = {r_addr[3][55:0], b};
                        else if (r >= 12'd20) begin
                            // option scan, one byte per cycle while i_en is high
                            if (r_sm == SC_LEN && r == sp + 12'd1) begin
                                n_sp = r_sp + ((b != 8'd0) ? b[6:0] : 7'd1);
                                n_sm = SC_TYPE;
                            end else if (r_sm == SC_OPT) begin
                                if (r == sp + 12'd1) begin
                                    if (b != 8'd20 || sp + 12'd20 > {5'd0, r_ip4len})
                                        n_sm = SC_DONE;
                                end else if (r >= sp + 12'd2 && r < sp + 12'd18) begin
                                    if (r < sp + 12'd10)
                                        n_tr[0] = {r_tr[0][55:0], b};
                                    else
                                        n_tr[1] = {r_tr[1][55:0], b};
                                    if (r == sp + 12'd17) begin
                                        n_ftr = 1'b1; n_sm = SC_DONE;
                                    end
                                end
                            end
                            if (n_sm == SC_TYPE && r == {5'd0, n_sp}) begin
                                if (r_oc >= i_cfg.max_opt
                                    || r + 12'd2 > {5'd0, r_ip4len} || b == 8'd0) begin
                                    n_sm = SC_DONE;
                                end else begin
                                    n_oc = r_oc + 6'd1;
                                    if (b == 8'd1) n_sp = n_sp + 7'd1;
                                    else if (b == i_cfg.ipv4_code) n_sm = SC_OPT;
                                    else n_sm = SC_LEN;
                                end
                            end
                        end
                        if (r + 12'd1 == {5'd0, (r == 12'd0) ? n_ip4len : r_ip4len}
                            && n_ph != PH_FAIL) begin
                            n_nho = r_nho + PW'(r_ip4len);
                            n_ph = PH_TCP;
                        end
                    end
                end
                PH_IP6: begin
                    if (r == 12'd0 && b[7:4] != 4'd6) begin
                        n_ph = PH_FAIL;
                    end else begin
                        if (r == 12'd6) begin
                            n_proto = {8'd0, b};
                            if (b == 8'd60) n_fcand = 1'b1;
                        end
                        if (r >= 12'd8 && r < 12'd40)
                            n_addr[r[4:3] - 2'd1] = {r_addr[r[4:3] - 2'd1][55:0], b};
                        if (r == 12'd39) begin
                            n_nho = r_nho + PW'(40);
                            walk = 1'b1; wproto = r_proto[7:0];
                        end
                    end
                end
                PH_EXT: begin
                    if (r == 12'd0) n_enext = b;
                    if (r == 12'd1)
                        n_elen = (r_proto == 16'd44) ? 12'd8 : ({4'd0, b} + 12'd1) << 3;
                    if (r_hc == HW'(1) && r_fcand) begin
                        if ((r == 12'd1 && b != 8'd3)
                            || (r == 12'd2 && b != i_cfg.ipv6_code)
                            || (r == 12'd3 && b != 8'd28)) begin
                            n_fcand = 1'b0;
                        end else if (r >= 12'd4 && r < 12'd12) begin
                            n_tr[0] = {r_tr[0][55:0], b};
                        end else if (r >= 12'd12 && r < 12'd20) begin
                            n_tr[1] = {r_tr[1][55:0], b};
                        end else if (r >= 12'd20 && r < 12'd28) begin
                            n_span = {r_span[55:0], b};
                            if (r == 12'd27) n_ftr = 1'b1;
                        end
                    end
                    advlen = (r == 12'd1) ? n_elen : r_elen;
                    if (r >= 12'd1 && r + 12'd1 == advlen) begin
                        n_nho = r_nho + PW'(advlen);
                        n_proto = {8'd0, r_enext};
                        walk = 1'b1; wproto = r_enext;
                    end
                end
                PH_TCP: begin
                    if (r < 12'd4)
                        n_port[r[1]] = {r_port[r[1]][7:0], b};
                    else if (r < 12'd12 && !r_fv6)
                        n_span = {r_span[55:0], b};
                    if (r == 12'd19) begin
                        n_fconn = 1'b1; n_ph = PH_DONE;
                    end
                end
                default: ;
            endcase
            // extension header walk
            if (walk) begin
                if (wproto == 8'd6) n_ph = PH_TCP;
                else if (32'(r_hc) >= MAX_EXT_HEADERS) n_ph = PH_FAIL;
                else if (wproto == 8'd0 || wproto == 8'd43 || wproto == 8'd60
                         || wproto == 8'd44) begin
                    n_hc = r_hc + 1'b1; n_elen = '0; n_ph = PH_EXT;
                end else n_ph = PH_FAIL;
            end
        end
    end

    // state registers, cleared at reset and at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos <= '0; r_nho <= '0; r_ph <= PH_ETH; r_proto <= '0;
            r_hc <= '0; r_oc <= '0; r_span <= '0;
            r_fv6 <= 1'b0; r_fconn <= 1'b0; r_ftr <= 1'b0; r_fcand <= 1'b0;
            r_ip4len <= '0; r_sm <= SC_DONE; r_sp <= '0; r_elen <= '0; r_enext <= '0;
            for (int i = 0; i < 4; i++) r_addr[i] <= '0;
            for (int i = 0; i < 2; i++) begin
                r_port[i] <= '0; r_tr[i] <= '0;
            end
        end else if (i_en) begin
            r_pos <= n_pos; r_nho <= n_nho; r_ph <= n_ph; r_proto <= n_proto;
            r_hc <= n_hc; r_oc <= n_oc; r_addr <= n_addr; r_port <= n_port;
            r_tr <= n_tr; r_span <= n_span; r_fv6 <= n_fv6; r_fconn <= n_fconn;
            r_ftr <= n_ftr; r_fcand <= n_fcand; r_ip4len <= n_ip4len; r_sm <= n_sm;
            r_sp <= n_sp; r_elen <= n_elen; r_enext <= n_enext;
        end
    end

    // result word formed from next state
    logic trace;
    assign o_res_valid = i_en && i_last;
    assign trace = n_fconn && n_ftr;
    always_comb begin
        o_res = '0;
        o_res.conn_valid  = n_fconn;
        o_res.is_ipv6     = n_fv6;
        o_res.trace_found = trace;
        if (n_fconn) begin
            if (n_fv6) begin
                o_res.src_addr_hi = n_addr[0]; o_res.src_addr_lo = n_addr[1];
                o_res.dst_addr_hi = n_addr[2]; o_res.dst_addr_lo = n_addr[3];
            end else begin
                o_res.src_addr_lo = {32'h0000ffff, n_addr[1][31:0]};
                o_res.dst_addr_lo = {32'h0000ffff, n_addr[3][31:0]};
            end
            o_res.src_port = n_port[0];
            o_res.dst_port = n_port[1];
        end
        if (trace) begin
            o_res.trace_id_hi = n_tr[0];
            o_res.trace_id_lo = n_tr[1];
            o_res.span_id     = n_span;
        end
    end
endmodule
`default_nettype wire

/* design/trace_option_header_parser_core.sv */
// trace option header parser
// frame bytes enter on the s_axis channel, one word per byte: tdata is the
// byte, tlast marks the final byte of the frame. one result word leaves on
// m_axis for every frame, formed from the byte marked last.
// the config channel writes ipv4 option code (0), ipv6 option code (1) and
// the ipv4 option limit (2); write only while no frame is in flight.
// throughput: one byte per cycle while s_axis_tready is high, set by the single
// pass of parse logic between the input byte and the parse state registers.
// latency: the result is registered and appears the cycle after the last
// byte is taken.
// reset clears the parse state and restores the register defaults; there is
// no clearing pass.
// when the receiver stalls, the result register holds its word; s_axis keeps
// taking bytes as long as the register is empty or is being drained, so a
// last byte waits only when a previous result is still held.
`default_nettype none
module trace_option_header_parser_core
    import tohp_pkg::*;
#(
    parameter int unsigned MAX_VLAN_TAGS   = MAX_VLAN_TAGS_DEF,
    parameter int unsigned MAX_EXT_HEADERS = MAX_EXT_HEADERS_DEF,
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data_byte
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // conn_valid, is_ipv6, trace_found, src_addr_hi, src_addr_lo, dst_addr_hi,
    // dst_addr_lo, src_port, dst_port, trace_id_hi, trace_id_lo, span_id, pad
    output logic [519:0]      m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data
);
    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    en;
    t_result r_out;
    logic    r_out_valid;

    tohp_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_cfg(cfg)
    );

    // a byte waits only if it is last and the result slot stays full
    assign s_axis_tready = !(s_axis_tlast && r_out_valid && !m_axis_tready);
    assign en = s_axis_tvalid && s_axis_tready;

    tohp_parser #(
        .MAX_VLAN_TAGS(MAX_VLAN_TAGS),
        .MAX_EXT_HEADERS(MAX_EXT_HEADERS),
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk, .i_rst_n, .i_en(en), .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .i_cfg(cfg), .o_res_valid(res_valid), .o_res(res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) r_out <= res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {5'd0, r_out.span_id, r_out.trace_id_lo, r_out.trace_id_hi,
                           r_out.dst_port, r_out.src_port, r_out.dst_addr_lo,
                           r_out.dst_addr_hi, r_out.src_addr_lo, r_out.src_addr_hi,
                           r_out.trace_found, r_out.is_ipv6, r_out.conn_valid};
endmodule
`default_nettype wire
